// ----- rtl/buzcbf_pkg.sv -----
// Package for the rolling-hash chunk boundary finder.
// Holds request codes, the front-to-back item type and default sizes.
// No dependencies.
package buzcbf_pkg;

   localparam int HASH_BITS_DEF  = 64;
   localparam int MAX_WINDOW_DEF = 64;
   localparam int WORD_W         = 64;
   localparam int QUEUE_AW       = 2;
   localparam int RESULT_AW      = 2;

   typedef enum logic [1:0] {
      REQ_DATA   = 2'd0,
      REQ_ADD_WR = 2'd1,
      REQ_REM_WR = 2'd2
   } req_kind_type;

   typedef enum logic [1:0] {
      OP_NONE,
      OP_DATA,
      OP_ADD_WR,
      OP_REM_WR
   } op_type;

   typedef enum logic {
      CSR_THRESHOLD = 1'b0,
      CSR_WINDOW    = 1'b1
   } csr_index_type;

   typedef struct packed {
      op_type            op;
      logic [7:0]        data_byte;
      logic              last;
      logic [7:0]        index;
      logic [WORD_W-1:0] word;
      logic [7:0]        oldest;
   } item_type;

endpackage

// ----- rtl/buzcbf_fifo.sv -----
// Small first-in first-out queue of flat words.
// Used between front and back and for results; no package dependencies.
module buzcbf_fifo #(
   parameter int WIDTH = 8,
   parameter int AW    = 2
) (
   input  logic             clock,
   input  logic             reset,
   input  logic             push,
   input  logic [WIDTH-1:0] wdata,
   output logic             full,
   input  logic             pop,
   output logic [WIDTH-1:0] rdata,
   output logic             empty,
   output logic [AW:0]      count
);
   localparam int DEPTH = 1 << AW;

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [AW-1:0]    wr_ptr_ff, wr_ptr_in;
   logic [AW-1:0]    rd_ptr_ff, rd_ptr_in;
   logic [AW:0]      count_ff, count_in;
   logic             do_push, do_pop;

   assign full    = (count_ff == (AW+1)'(DEPTH));
   assign empty   = (count_ff == '0);
   assign count   = count_ff;
   assign rdata   = mem_ff[rd_ptr_ff];
   assign do_push = push && !full;
   assign do_pop  = pop && !empty;

   always_comb begin
      wr_ptr_in = do_push ? wr_ptr_ff + 1'b1 : wr_ptr_ff;
      rd_ptr_in = do_pop ? rd_ptr_ff + 1'b1 : rd_ptr_ff;
      count_in  = count_ff;
      if (do_push && !do_pop) begin
         count_in = count_ff + 1'b1;
      end else if (do_pop && !do_push) begin
         count_in = count_ff - 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   always_ff @(posedge clock) begin
      if (do_push) begin
         mem_ff[wr_ptr_ff] <= wdata;
      end
   end

endmodule

// ----- rtl/buzcbf_front.sv -----
// Front end: accepts requests, classifies them and runs the byte delay line.
// Depends on buzcbf_pkg; emits one item per useful request toward the back.
module buzcbf_front #(
   parameter int MAX_WINDOW = buzcbf_pkg::MAX_WINDOW_DEF
) (
   input  logic                        clock,
   input  logic                        reset,
   input  logic [6:0]                  window_len,
   input  logic                        push,
   output logic                        full,
   input  logic [1:0]                  req_type,
   input  logic [7:0]                  req_data_byte,
   input  logic                        req_last_in_buffer,
   input  logic [7:0]                  req_table_index,
   input  logic [buzcbf_pkg::WORD_W-1:0] req_table_word,
   output logic                        q_push,
   output buzcbf_pkg::item_type        q_item,
   input  logic                        q_full
);
   import buzcbf_pkg::*;

   localparam int PW = (MAX_WINDOW > 1) ? $clog2(MAX_WINDOW) : 1;
   localparam int FW = $clog2(MAX_WINDOW + 1);
   localparam int CW = (FW > 7) ? FW : 7;
   localparam int XW = CW + 1;

   logic [7:0]    hist_mem_ff [MAX_WINDOW];
   logic [PW-1:0] ptr_ff, ptr_in;
   logic [FW-1:0] fill_ff, fill_in;
   logic [7:0]    hist_rd_ff;
   logic          old_valid_ff;
   logic          f1_valid_ff, f1_valid_in;
   op_type        f1_op_ff;
   logic [7:0]    f1_byte_ff;
   logic          f1_last_ff;
   logic [7:0]    f1_index_ff;
   logic [WORD_W-1:0] f1_word_ff;

   op_type        op;
   logic          accept;
   logic          take_data;
   logic [CW-1:0] win_ext;
   logic [CW-1:0] win_eff;
   logic [XW-1:0] ptr_ext;
   logic [XW-1:0] old_sum;
   logic [PW-1:0] old_pos;
   logic          old_valid;

   assign full      = f1_valid_ff && q_full;
   assign accept    = push && !full;
   assign take_data = accept && (op == OP_DATA);

   always_comb begin
      unique case (req_kind_type'(req_type))
         REQ_DATA:   op = OP_DATA;
         REQ_ADD_WR: op = OP_ADD_WR;
         REQ_REM_WR: op = OP_REM_WR;
         default:    op = OP_NONE;
      endcase
   end

   always_comb begin
      win_ext = CW'(window_len);
      if (win_ext == '0) begin
         win_eff = CW'(1);
      end else if (win_ext > CW'(MAX_WINDOW)) begin
         win_eff = CW'(MAX_WINDOW);
      end else begin
         win_eff = win_ext;
      end
      ptr_ext = XW'(ptr_ff);
      if (ptr_ext >= XW'(win_eff)) begin
         old_sum = ptr_ext - XW'(win_eff);
      end else begin
         old_sum = ptr_ext + XW'(MAX_WINDOW) - XW'(win_eff);
      end
      old_pos   = old_sum[PW-1:0];
      old_valid = (XW'(old_pos) < XW'(fill_ff));
      ptr_in    = (ptr_ff == PW'(MAX_WINDOW - 1)) ? '0 : ptr_ff + 1'b1;
      fill_in   = (fill_ff == FW'(MAX_WINDOW)) ? fill_ff : fill_ff + 1'b1;
   end

   always_comb begin
      f1_valid_in = f1_valid_ff;
      if (accept) begin
         f1_valid_in = (op != OP_NONE);
      end else if (!q_full) begin
         f1_valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         f1_valid_ff <= 1'b0;
         ptr_ff      <= '0;
         fill_ff     <= '0;
      end else begin
         f1_valid_ff <= f1_valid_in;
         if (take_data) begin
            ptr_ff  <= ptr_in;
            fill_ff <= fill_in;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (accept) begin
         f1_op_ff    <= op;
         f1_byte_ff  <= req_data_byte;
         f1_last_ff  <= req_last_in_buffer;
         f1_index_ff <= req_table_index;
         f1_word_ff  <= req_table_word;
      end
      if (take_data) begin
         hist_rd_ff         <= hist_mem_ff[old_pos];
         old_valid_ff       <= old_valid;
         hist_mem_ff[ptr_ff] <= req_data_byte;
      end
   end

   assign q_push = f1_valid_ff && !q_full;

   always_comb begin
      q_item.op        = f1_op_ff;
      q_item.data_byte = f1_byte_ff;
      q_item.last      = f1_last_ff;
      q_item.index     = f1_index_ff;
      q_item.word      = f1_word_ff;
      q_item.oldest    = old_valid_ff ? hist_rd_ff : 8'd0;
   end

endmodule

// ----- rtl/buzcbf_back.sv -----
// Back end: add and remove tables, rolling hash update, threshold compare.
// Depends on buzcbf_pkg and buzcbf_fifo (result queue).
module buzcbf_back #(
   parameter int HASH_BITS = buzcbf_pkg::HASH_BITS_DEF
) (
   input  logic                          clock,
   input  logic                          reset,
   input  logic [buzcbf_pkg::WORD_W-1:0] threshold,
   input  logic                          q_empty,
   output logic                          q_pop,
   input  buzcbf_pkg::item_type          q_item,
   output logic                          empty,
   input  logic                          pop,
   output logic                          rsp_boundary_found,
   output logic [buzcbf_pkg::WORD_W-1:0] rsp_hash_value
);
   import buzcbf_pkg::*;

   localparam int RW = 1 + WORD_W;
   localparam int OUT_DEPTH = 1 << RESULT_AW;

   logic [HASH_BITS-1:0] add_mem_ff [256];
   logic [HASH_BITS-1:0] rem_mem_ff [256];
   logic [HASH_BITS-1:0] add_rd_ff;
   logic [HASH_BITS-1:0] rem_rd_ff;
   logic [HASH_BITS-1:0] hash_ff, hash_in;
   logic                 b1_valid_ff, b1_valid_in;
   logic                 b1_last_ff;

   logic [HASH_BITS-1:0] rot;
   logic                 hit;
   logic                 res_push;
   logic [RW-1:0]        res_wdata;
   logic [RW-1:0]        res_rdata;
   logic [RESULT_AW:0]   res_count;
   logic                 res_full;
   logic [RESULT_AW+1:0] pending;

   assign pending     = (RESULT_AW+2)'(res_count) + (RESULT_AW+2)'(b1_valid_ff);
   assign q_pop       = !q_empty && (pending < (RESULT_AW+2)'(OUT_DEPTH));
   assign b1_valid_in = q_pop && (q_item.op == OP_DATA);

   assign rot       = {hash_ff[HASH_BITS-2:0], hash_ff[HASH_BITS-1]};
   assign hash_in   = rem_rd_ff ^ rot ^ add_rd_ff;
   assign hit       = (hash_in <= threshold[HASH_BITS-1:0]);
   assign res_push  = b1_valid_ff && (hit || b1_last_ff);
   assign res_wdata = {hit, WORD_W'(hash_in)};

   always_ff @(posedge clock) begin
      if (reset) begin
         b1_valid_ff <= 1'b0;
         hash_ff     <= '0;
      end else begin
         b1_valid_ff <= b1_valid_in;
         if (b1_valid_ff) begin
            hash_ff <= hash_in;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (q_pop) begin
         b1_last_ff <= q_item.last;
         unique case (q_item.op)
            OP_ADD_WR: add_mem_ff[q_item.index] <= q_item.word[HASH_BITS-1:0];
            OP_REM_WR: rem_mem_ff[q_item.index] <= q_item.word[HASH_BITS-1:0];
            OP_DATA: begin
               add_rd_ff <= add_mem_ff[q_item.data_byte];
               rem_rd_ff <= rem_mem_ff[q_item.oldest];
            end
            default: ;
         endcase
      end
   end

   buzcbf_fifo #(
      .WIDTH (RW),
      .AW    (RESULT_AW)
   ) u_result_q (
      .clock (clock),
      .reset (reset),
      .push  (res_push),
      .wdata (res_wdata),
      .full  (res_full),
      .pop   (pop),
      .rdata (res_rdata),
      .empty (empty),
      .count (res_count)
   );

   assign rsp_boundary_found = res_rdata[RW-1] && !res_full | res_rdata[RW-1];
   assign rsp_hash_value     = res_rdata[WORD_W-1:0];

endmodule

// ----- rtl/buzhash_chunk_boundary_finder.sv -----
// Rolling-hash content-defined chunk boundary finder: one data byte per clock cycle
// while full is low; table-entry writes take one request slot each. A byte's result
// passes the front register, item queue and table read registers to the result
// queue; the rate is set by the hash recurrence (rotate and xor) fed by registered
// reads of the add and remove tables. Load every table entry a data stream can touch
// before sending data. Registers: threshold at byte address 0, window_len at 8.
module buzhash_chunk_boundary_finder #(
   parameter int HASH_BITS  = buzcbf_pkg::HASH_BITS_DEF,
   parameter int MAX_WINDOW = buzcbf_pkg::MAX_WINDOW_DEF
) (
   input  logic                          clock,
   input  logic                          reset,
   input  logic                          push,
   output logic                          full,
   input  logic [1:0]                    req_type,
   input  logic [7:0]                    req_data_byte,
   input  logic                          req_last_in_buffer,
   input  logic [7:0]                    req_table_index,
   input  logic [buzcbf_pkg::WORD_W-1:0] req_table_word,
   output logic                          empty,
   input  logic                          pop,
   output logic                          rsp_boundary_found,
   output logic [buzcbf_pkg::WORD_W-1:0] rsp_hash_value,
   input  logic                          psel,
   input  logic                          penable,
   input  logic                          pwrite,
   input  logic [3:0]                    paddr,
   input  logic [63:0]                   pwdata,
   output logic [63:0]                   prdata,
   output logic                          pready
);
   import buzcbf_pkg::*;

   localparam int IW = $bits(item_type);

   logic [WORD_W-1:0] threshold_ff;
   logic [6:0]        window_len_ff;
   logic              csr_write;
   csr_index_type     csr_index;

   logic              q_push, q_full, q_pop, q_empty;
   item_type          q_wr_item, q_rd_item;
   logic [IW-1:0]     q_rdata;
   logic [QUEUE_AW:0] q_count;

   assign pready    = 1'b1;
   assign csr_write = psel && penable && pwrite && pready;
   assign csr_index = csr_index_type'(paddr[3]);

   always_ff @(posedge clock) begin
      if (reset) begin
         threshold_ff  <= '0;
         window_len_ff <= 7'd64;
      end else if (csr_write) begin
         unique case (csr_index)
            CSR_THRESHOLD: threshold_ff  <= pwdata;
            CSR_WINDOW:    window_len_ff <= pwdata[6:0];
            default: ;
         endcase
      end
   end

   always_comb begin
      unique case (csr_index)
         CSR_THRESHOLD: prdata = threshold_ff;
         CSR_WINDOW:    prdata = 64'(window_len_ff);
         default:       prdata = '0;
      endcase
   end

   buzcbf_front #(
      .MAX_WINDOW (MAX_WINDOW)
   ) u_front (
      .clock              (clock),
      .reset              (reset),
      .window_len         (window_len_ff),
      .push               (push),
      .full               (full),
      .req_type           (req_type),
      .req_data_byte      (req_data_byte),
      .req_last_in_buffer (req_last_in_buffer),
      .req_table_index    (req_table_index),
      .req_table_word     (req_table_word),
      .q_push             (q_push),
      .q_item             (q_wr_item),
      .q_full             (q_full)
   );

   buzcbf_fifo #(
      .WIDTH (IW),
      .AW    (QUEUE_AW)
   ) u_item_q (
      .clock (clock),
      .reset (reset),
      .push  (q_push),
      .wdata (q_wr_item),
      .full  (q_full),
      .pop   (q_pop),
      .rdata (q_rdata),
      .empty (q_empty),
      .count (q_count)
   );

   assign q_rd_item = item_type'(q_rdata);

   buzcbf_back #(
      .HASH_BITS (HASH_BITS)
   ) u_back (
      .clock              (clock),
      .reset              (reset),
      .threshold          (threshold_ff),
      .q_empty            (q_empty || (q_count == '0)),
      .q_pop              (q_pop),
      .q_item             (q_rd_item),
      .empty              (empty),
      .pop                (pop),
      .rsp_boundary_found (rsp_boundary_found),
      .rsp_hash_value     (rsp_hash_value)
   );

endmodule

// ----- bench/tb_top.sv -----
// Self-checking bench for buzhash_chunk_boundary_finder: table loads, data bytes, CSR phases.
// A local rolling-hash predictor queues expected chunk results; a monitor compares each pop.
// Depends on buzcbf_pkg and the block's RTL only.
module tb_top;
   timeunit 1ns;
   timeprecision 1ps;

   import buzcbf_pkg::*;

   localparam int          CLK_PERIOD     = 4;
   localparam int          RESET_CYCLES   = 4;
   localparam int          DRAIN_CYCLES   = 12;
   localparam int          HOLDOFF_CYCLES = 300;
   localparam int          STALL_LIMIT    = 3000;
   localparam int          PHASE_ITEMS    = 200;
   localparam int          NUM_PHASES     = 6;
   localparam int          NUM_DIR_ROWS   = 22;
   localparam logic [1:0]  REQ_UNUSED     = 2'd3;
   localparam logic [3:0]  ADDR_THRESHOLD = {CSR_THRESHOLD, 3'b000};
   localparam logic [3:0]  ADDR_WINDOW    = {CSR_WINDOW, 3'b000};
   localparam logic [63:0] ONES           = {64{1'b1}};
   localparam logic [63:0] TOP_BIT        = 64'h8000_0000_0000_0000;

   typedef struct packed {
      logic [1:0]  kind;
      logic [7:0]  data;
      logic        last;
      logic [7:0]  idx;
      logic [63:0] word;
   } request_type;

   typedef struct packed {
      logic        bnd;
      logic [63:0] hash;
   } chunk_type;

   typedef struct packed {
      request_type rq;
      logic        typed;
      chunk_type   want;
   } dir_row_type;

   typedef enum int {RX_STREAM, RX_COIN, RX_SPARSE, RX_PERIODIC} rx_mode_type;

   logic        clock = 1'b0;
   logic        reset = 1'b1;
   logic        push = 1'b0;
   logic        full;
   logic [1:0]  req_type = 2'd0;
   logic [7:0]  req_data_byte = 8'd0;
   logic        req_last_in_buffer = 1'b0;
   logic [7:0]  req_table_index = 8'd0;
   logic [63:0] req_table_word = 64'd0;
   logic        empty;
   logic        pop = 1'b0;
   logic        rsp_boundary_found;
   logic [63:0] rsp_hash_value;
   logic        psel = 1'b0;
   logic        penable = 1'b0;
   logic        pwrite = 1'b0;
   logic [3:0]  paddr = 4'd0;
   logic [63:0] pwdata = 64'd0;
   logic [63:0] prdata;
   logic        pready;

   // predictor state
   logic [63:0] roll_hash;
   logic [7:0]  hist [64];
   logic [5:0]  hist_ptr;
   logic [63:0] add_tbl [256];
   logic [63:0] rem_tbl [256];
   logic [63:0] thr_cfg;
   logic [6:0]  win_cfg;

   chunk_type chunk_q [$];
   int     errors = 0;
   int     hold_requests = 0;
   int     hold_served = 0;
   int     holdoff_left = 0;
   int     stretch_left = 0;
   int     idle_cycles = 0;
   rx_mode_type rx_mode = RX_STREAM;

   dir_row_type dir_rows [NUM_DIR_ROWS] = '{
      '{'{REQ_REM_WR, 8'h00, 1'b0, 8'h00, 64'h0},          1'b0, '{1'b0, 64'h0}},
      '{'{REQ_ADD_WR, 8'h00, 1'b0, 8'h00, 64'h0},          1'b0, '{1'b0, 64'h0}},
      '{'{REQ_ADD_WR, 8'h00, 1'b0, 8'hFF, ONES},           1'b0, '{1'b0, 64'h0}},
      '{'{REQ_REM_WR, 8'h00, 1'b0, 8'hFF, TOP_BIT | 64'h1}, 1'b0, '{1'b0, 64'h0}},
      '{'{REQ_DATA,   8'h00, 1'b0, 8'h00, 64'h0},          1'b1, '{1'b1, 64'h0}},
      '{'{REQ_DATA,   8'h00, 1'b1, 8'h00, 64'h0},          1'b1, '{1'b1, 64'h0}},
      '{'{REQ_DATA,   8'hFF, 1'b1, 8'h00, 64'h0},          1'b1, '{1'b0, ONES}},
      '{'{REQ_DATA,   8'hFF, 1'b0, 8'hFF, ONES},           1'b1, '{1'b1, 64'h0}},
      '{'{REQ_UNUSED, 8'hFF, 1'b1, 8'hFF, ONES},           1'b0, '{1'b0, 64'h0}},
      '{'{REQ_ADD_WR, 8'h00, 1'b0, 8'h5A, 64'h1},          1'b0, '{1'b0, 64'h0}},
      '{'{REQ_REM_WR, 8'h00, 1'b0, 8'h5A, TOP_BIT},        1'b0, '{1'b0, 64'h0}},
      '{'{REQ_ADD_WR, 8'h00, 1'b0, 8'hA5, TOP_BIT},        1'b0, '{1'b0, 64'h0}},
      '{'{REQ_REM_WR, 8'h00, 1'b0, 8'hA5, 64'h1},          1'b0, '{1'b0, 64'h0}},
      '{'{REQ_DATA,   8'h5A, 1'b0, 8'hFF, ONES},           1'b0, '{1'b0, 64'h0}},
      '{'{REQ_DATA,   8'hA5, 1'b1, 8'h00, 64'h0},          1'b0, '{1'b0, 64'h0}},
      '{'{REQ_DATA,   8'hFF, 1'b0, 8'h00, 64'h0},          1'b0, '{1'b0, 64'h0}},
      '{'{REQ_DATA,   8'h00, 1'b1, 8'hFF, ONES},           1'b0, '{1'b0, 64'h0}},
      '{'{REQ_ADD_WR, 8'h00, 1'b0, 8'h00, 64'hFFFF_FFFF_0000_0000}, 1'b0, '{1'b0, 64'h0}},
      '{'{REQ_DATA,   8'h00, 1'b1, 8'h00, 64'h0},          1'b0, '{1'b0, 64'h0}},
      '{'{REQ_DATA,   8'hA5, 1'b0, 8'h00, 64'h0},          1'b0, '{1'b0, 64'h0}},
      '{'{REQ_UNUSED, 8'h00, 1'b0, 8'h00, 64'h0},          1'b0, '{1'b0, 64'h0}},
      '{'{REQ_DATA,   8'h5A, 1'b1, 8'h00, 64'h0},          1'b0, '{1'b0, 64'h0}}
   };

   buzhash_chunk_boundary_finder DUT (
      .clock              (clock),
      .reset              (reset),
      .push               (push),
      .full               (full),
      .req_type           (req_type),
      .req_data_byte      (req_data_byte),
      .req_last_in_buffer (req_last_in_buffer),
      .req_table_index    (req_table_index),
      .req_table_word     (req_table_word),
      .empty              (empty),
      .pop                (pop),
      .rsp_boundary_found (rsp_boundary_found),
      .rsp_hash_value     (rsp_hash_value),
      .psel               (psel),
      .penable            (penable),
      .pwrite             (pwrite),
      .paddr              (paddr),
      .pwdata             (pwdata),
      .prdata             (prdata),
      .pready             (pready)
   );

   always #(CLK_PERIOD / 2) clock = ~clock;

   task automatic buzhash_predict(input request_type rq, output bit got,
                                  output chunk_type res);
      logic [6:0]  w;
      logic [5:0]  oldest_pos;
      logic [63:0] h;
      got = 1'b0;
      res = '0;
      case (rq.kind)
         REQ_ADD_WR: add_tbl[rq.idx] = rq.word;
         REQ_REM_WR: rem_tbl[rq.idx] = rq.word;
         REQ_DATA: begin
            w = (win_cfg == 7'd0) ? 7'd1 : (win_cfg > 7'd64) ? 7'd64 : win_cfg;
            oldest_pos = hist_ptr - w[5:0];
            h = rem_tbl[hist[oldest_pos]] ^ {roll_hash[62:0], roll_hash[63]} ^ add_tbl[rq.data];
            roll_hash = h;
            hist[hist_ptr] = rq.data;
            hist_ptr = hist_ptr + 6'd1;
            if (h <= thr_cfg || rq.last) begin
               got = 1'b1;
               res.bnd = (h <= thr_cfg);
               res.hash = h;
            end
         end
         default: ;
      endcase
   endtask

   task automatic send_req(input request_type rq, input logic typed, input chunk_type want);
      bit        got;
      chunk_type pred;
      push <= 1'b1;
      req_type <= rq.kind;
      req_data_byte <= rq.data;
      req_last_in_buffer <= rq.last;
      req_table_index <= rq.idx;
      req_table_word <= rq.word;
      do @(posedge clock); while (full);
      buzhash_predict(rq, got, pred);
      if (typed) chunk_q.push_back(want);
      else if (got) chunk_q.push_back(pred);
   endtask

   task automatic idle_sender(input int n);
      push <= 1'b0;
      repeat (n) @(posedge clock);
   endtask

   task automatic settle();
      push <= 1'b0;
      while (chunk_q.size() != 0) @(posedge clock);
      repeat (DRAIN_CYCLES) @(posedge clock);
   endtask

   task automatic csr_write(input logic [3:0] addr, input logic [63:0] data);
      psel <= 1'b1;
      penable <= 1'b0;
      pwrite <= 1'b1;
      paddr <= addr;
      pwdata <= data;
      @(posedge clock);
      penable <= 1'b1;
      do @(posedge clock); while (!pready);
      psel <= 1'b0;
      penable <= 1'b0;
      @(posedge clock);
      if (addr == ADDR_THRESHOLD) thr_cfg = data;
      else win_cfg = data[6:0];
   endtask

   task automatic csr_readback(input logic [3:0] addr, input string name);
      logic [63:0] got;
      logic [63:0] want;
      want = (addr == ADDR_THRESHOLD) ? thr_cfg : {57'd0, win_cfg};
      psel <= 1'b1;
      penable <= 1'b0;
      pwrite <= 1'b0;
      paddr <= addr;
      @(posedge clock);
      penable <= 1'b1;
      do @(posedge clock); while (!pready);
      got = prdata;
      psel <= 1'b0;
      penable <= 1'b0;
      @(posedge clock);
      if (got !== want) begin
         $error("%s: expected %h, got %h", name, want, got);
         errors++;
      end
   endtask

   function automatic request_type random_req();
      request_type rq;
      int          r;
      r = $urandom_range(0, 99);
      rq.data = 8'($urandom_range(0, 255));
      rq.last = ($urandom_range(0, 7) == 0);
      rq.idx = 8'($urandom_range(0, 255));
      rq.word = {$urandom, $urandom};
      if (r < 86) rq.kind = REQ_DATA;
      else if (r < 91) rq.kind = REQ_ADD_WR;
      else if (r < 96) rq.kind = REQ_REM_WR;
      else rq.kind = REQ_UNUSED;
      return rq;
   endfunction

   // response monitor and pop pattern
   always @(posedge clock) begin
      chunk_type want;
      if (reset) begin
         pop <= 1'b0;
      end else begin
         if (pop && !empty) begin
            if (chunk_q.size() == 0) begin
               $error("unexpected result: boundary_found %b hash_value %h",
                      rsp_boundary_found, rsp_hash_value);
               errors++;
            end else begin
               want = chunk_q.pop_front();
               if (rsp_boundary_found !== want.bnd) begin
                  $error("boundary_found: expected %b, got %b", want.bnd, rsp_boundary_found);
                  errors++;
               end
               if (rsp_hash_value !== want.hash) begin
                  $error("hash_value: expected %h, got %h", want.hash, rsp_hash_value);
                  errors++;
               end
            end
         end
         if (hold_requests != hold_served) begin
            hold_served = hold_requests;
            holdoff_left = HOLDOFF_CYCLES;
         end
         if (stretch_left == 0) begin
            rx_mode = rx_mode_type'($urandom_range(0, 3));
            stretch_left = $urandom_range(8, 80);
         end else begin
            stretch_left--;
         end
         if (holdoff_left > 0) begin
            holdoff_left--;
            pop <= 1'b0;
         end else begin
            case (rx_mode)
               RX_STREAM: pop <= 1'b1;
               RX_COIN:   pop <= ($urandom_range(0, 1) == 1);
               RX_SPARSE: pop <= ($urandom_range(0, 3) == 0);
               default:   pop <= ((stretch_left % 8) < 3);
            endcase
         end
      end
   end

   always @(posedge clock) begin
      if ((push && !full) || (pop && !empty) || (psel && penable)) idle_cycles = 0;
      else idle_cycles++;
      if (idle_cycles >= STALL_LIMIT) begin
         $display("tb_top: errors");
         $finish;
      end
   end

   initial begin
      request_type rq;
      chunk_type   none;
      int          sent;
      int          blen;
      none = '0;
      roll_hash = '0;
      hist_ptr = '0;
      foreach (hist[i]) hist[i] = 8'd0;
      foreach (add_tbl[i]) add_tbl[i] = '0;
      foreach (rem_tbl[i]) rem_tbl[i] = '0;
      thr_cfg = '0;
      win_cfg = 7'd64;

      repeat (RESET_CYCLES) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      csr_readback(ADDR_THRESHOLD, "threshold");
      csr_readback(ADDR_WINDOW, "window_len");

      for (int i = 0; i < NUM_DIR_ROWS; i++) begin
         send_req(dir_rows[i].rq, dir_rows[i].typed, dir_rows[i].want);
      end

      // load every entry of both tables before random data
      for (int i = 0; i < 512; i++) begin
         rq.kind = (i % 2 == 0) ? REQ_ADD_WR : REQ_REM_WR;
         rq.data = 8'($urandom_range(0, 255));
         rq.last = 1'($urandom_range(0, 1));
         rq.idx = 8'(i / 2);
         rq.word = {$urandom, $urandom};
         send_req(rq, 1'b0, none);
         if ($urandom_range(0, 15) == 0) idle_sender($urandom_range(1, 6));
      end

      for (int ph = 0; ph < NUM_PHASES; ph++) begin
         settle();
         case (ph)
            0: begin
               csr_write(ADDR_THRESHOLD, 64'd0);
               csr_write(ADDR_WINDOW, 64'd64);
            end
            1: begin
               csr_write(ADDR_THRESHOLD, ONES);
               csr_write(ADDR_WINDOW, 64'd1);
            end
            2: begin
               csr_write(ADDR_THRESHOLD, 64'h3FFF_FFFF_FFFF_FFFF);
               csr_write(ADDR_WINDOW, 64'd0);
            end
            3: begin
               csr_write(ADDR_THRESHOLD, {$urandom, $urandom});
               csr_write(ADDR_WINDOW, 64'd127);
            end
            4: begin
               csr_write(ADDR_THRESHOLD, TOP_BIT);
               csr_write(ADDR_WINDOW, 64'($urandom_range(1, 64)));
            end
            default: begin
               csr_write(ADDR_THRESHOLD, 64'h0FFF_FFFF_FFFF_FFFF);
               csr_write(ADDR_WINDOW, 64'd2);
            end
         endcase
         csr_readback(ADDR_THRESHOLD, "threshold");
         csr_readback(ADDR_WINDOW, "window_len");

         // hold off the receiver while every byte hits, to back up the input
         if (ph == 1) hold_requests++;
         sent = 0;
         while (sent < PHASE_ITEMS) begin
            blen = $urandom_range(1, 48);
            for (int k = 0; k < blen; k++) begin
               rq = random_req();
               send_req(rq, 1'b0, none);
               if (rq.kind != REQ_UNUSED) sent++;
            end
            if ($urandom_range(0, 3) != 0) idle_sender($urandom_range(1, 10));
         end
      end

      settle();
      if (errors == 0) begin
         $display("tb_top: clean");
      end else begin
         $display("tb_top: errors");
      end
      $finish;
   end
endmodule
